[hdl/matrix_multiply_assert.svh]
// ----------------------------------------------------------------------------
// matrix_multiply_assert.svh
// assertion macros for the matrix multiply block
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix_multiply assertion failed");

// next-cycle implication
`define MM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix_multiply assertion failed");

`else

`define MM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hdl/mm_pkg.sv]
// ----------------------------------------------------------------------------
// mm_pkg
// shared types, constants and helpers for the matrix multiply block
// ----------------------------------------------------------------------------
package mm_pkg;

   localparam int MAX_DIM   = 8;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int DIM_W     = 4;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ELEM_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int ACC_W     = PROD_W + IDX_W;
   localparam int CSR_IDX_W = 2;
   localparam int CMD_W     = 2;
   localparam int STAT_W    = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd1;
   localparam logic [STAT_W-1:0] ST_SAT      = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_ROWS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_COLS = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [IDX_W-1:0]         elem_row;
      logic [IDX_W-1:0]         elem_col;
      logic signed [ELEM_W-1:0] elem_value;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] prod_value;
      logic [IDX_W-1:0]         prod_row;
      logic [IDX_W-1:0]         prod_col;
      logic                     last;
      logic [STAT_W-1:0]        status;
   } rsp_type;

   // control that follows one multiply-accumulate term down the pipe
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_term;
      logic             last_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[hdl/matrix_multiply.sv]
// ----------------------------------------------------------------------------
// matrix_multiply
// dense C = A x B on signed Q16.16 elements, operands held in two on-chip stores
//
//   channel   ports                          handshake
//   request   start, busy, req_data          start && !busy
//   response  rsp_valid, rsp_data            one-cycle strobe, no stall
//   csr       csr_we, csr_index, csr_wdata   write on csr_we
//
// a load writes its element into the store and busy stays low
// a compute with a dimension mismatch gives its error beat on the next cycle
// a compute keeps busy high until its final beat: one multiply-accumulate per
// cycle through the single read port of each store and the one MAC unit
// reset is synchronous; the stores are not cleared and must be loaded first
// ----------------------------------------------------------------------------
`include "matrix_multiply_assert.svh"

module matrix_multiply
   import mm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_type              req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   logic [DIM_W-1:0] left_rows_ff, left_cols_ff, right_rows_ff, right_cols_ff;
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   tag_type          tag_in, tag1_ff;

   logic signed [ELEM_W-1:0] left_mem  [DEPTH];
   logic signed [ELEM_W-1:0] right_mem [DEPTH];
   logic signed [ELEM_W-1:0] left_q_ff, right_q_ff;

   logic accept, load_left, load_right, is_compute, mismatch, go, err_beat;
   logic last_term, last_row, last_col, mac_done;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign load_left  = accept && (req_data.cmd == CMD_LOAD_LEFT);
   assign load_right = accept && (req_data.cmd == CMD_LOAD_RIGHT);
   assign is_compute = accept && (req_data.cmd == CMD_COMPUTE);
   assign mismatch   = (left_cols_ff != right_rows_ff);
   assign go         = is_compute && !mismatch;
   assign err_beat   = is_compute && mismatch;

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= DIM_W'(MAX_DIM);
         left_cols_ff  <= DIM_W'(MAX_DIM);
         right_rows_ff <= DIM_W'(MAX_DIM);
         right_cols_ff <= DIM_W'(MAX_DIM);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEFT_ROWS:  left_rows_ff  <= clamp_dim(csr_wdata);
            CSR_LEFT_COLS:  left_cols_ff  <= clamp_dim(csr_wdata);
            CSR_RIGHT_ROWS: right_rows_ff <= clamp_dim(csr_wdata);
            CSR_RIGHT_COLS: right_cols_ff <= clamp_dim(csr_wdata);
            default: ;
         endcase
      end
   end

   // index sequencer
   assign last_term = ((DIM_W'(k_ff) + DIM_W'(1)) == left_cols_ff);
   assign last_row  = ((DIM_W'(i_ff) + DIM_W'(1)) == left_rows_ff);
   assign last_col  = ((DIM_W'(j_ff) + DIM_W'(1)) == right_cols_ff);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      tag_in   = '0;
      case (state_ff)
         S_IDLE: begin
            if (go) begin
               state_in = S_ISSUE;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         S_ISSUE: begin
            tag_in.valid     = 1'b1;
            tag_in.first     = (k_ff == '0);
            tag_in.last_term = last_term;
            tag_in.last_elem = last_term && last_row && last_col;
            tag_in.row       = i_ff;
            tag_in.col       = j_ff;
            if (!last_term) begin
               k_in = k_ff + IDX_W'(1);
            end else begin
               k_in = '0;
               if (!last_col) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  if (last_row) begin
                     state_in = S_DRAIN;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
               end
            end
         end
         S_DRAIN: begin
            if (mac_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tag1_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tag1_ff  <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   // operand stores
   always_ff @(posedge clock) begin
      if (load_left) begin
         left_mem[{req_data.elem_row, req_data.elem_col}] <= req_data.elem_value;
      end
      left_q_ff <= left_mem[{i_ff, k_ff}];
   end

   always_ff @(posedge clock) begin
      if (load_right) begin
         right_mem[{req_data.elem_row, req_data.elem_col}] <= req_data.elem_value;
      end
      right_q_ff <= right_mem[{k_ff, j_ff}];
   end

   mm_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .tag         (tag1_ff),
      .left_value  (left_q_ff),
      .right_value (right_q_ff),
      .err_beat    (err_beat),
      .done        (mac_done),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // a mismatching compute answers with a single error beat
   `MM_ASSERT_NXT(a_mismatch_beat, clock, reset, err_beat,
                  rsp_valid && rsp_data.last && (rsp_data.status == ST_MISMATCH))
   // the run ends together with its final beat
   `MM_ASSERT_IMP(a_end_with_last, clock, reset, $fell(busy), rsp_valid && rsp_data.last)
   // loads never produce a beat
   `MM_ASSERT_NXT(a_load_quiet, clock, reset, load_left || load_right, !rsp_valid)

endmodule

[hdl/mm_mac.sv]
// ----------------------------------------------------------------------------
// mm_mac
// multiply, accumulate, shift/saturate and result register
// ----------------------------------------------------------------------------
module mm_mac
   import mm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  tag_type                  tag,
   input  logic signed [ELEM_W-1:0] left_value,
   input  logic signed [ELEM_W-1:0] right_value,
   input  logic                     err_beat,
   output logic                     done,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data
);

   tag_type                  tag2_ff, tag3_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  shifted;
   logic                     fits;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   assign prod_in = left_value * right_value;

   always_comb begin
      acc_in = acc_ff;
      if (tag2_ff.valid) begin
         acc_in = (tag2_ff.first ? ACC_W'(0) : acc_ff)
                + {{IDX_W{prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   // floor shift to the output scale, then range check
   assign shifted = acc_ff >>> FRAC_BITS;
   assign fits    = (shifted[ACC_W-1:ELEM_W-1] == '0) || (shifted[ACC_W-1:ELEM_W-1] == '1);

   always_comb begin
      rsp_valid_in = err_beat || (tag3_ff.valid && tag3_ff.last_term);
      rsp_in       = rsp_ff;
      if (err_beat) begin
         rsp_in.prod_value = '0;
         rsp_in.prod_row   = '0;
         rsp_in.prod_col   = '0;
         rsp_in.last       = 1'b1;
         rsp_in.status     = ST_MISMATCH;
      end else if (tag3_ff.valid && tag3_ff.last_term) begin
         rsp_in.prod_row = tag3_ff.row;
         rsp_in.prod_col = tag3_ff.col;
         rsp_in.last     = tag3_ff.last_elem;
         if (fits) begin
            rsp_in.prod_value = shifted[ELEM_W-1:0];
            rsp_in.status     = ST_OK;
         end else begin
            rsp_in.prod_value = shifted[ACC_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                                 : {1'b0, {(ELEM_W-1){1'b1}}};
            rsp_in.status     = ST_SAT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag2_ff      <= tag;
         tag3_ff      <= tag2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign done      = tag3_ff.valid && tag3_ff.last_elem;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
